// ===== rtl/sqt_pkg.sv =====
// Package for the sprite quad transform: field widths, register indexes
// and the output saturation limits. No dependencies.
`default_nettype none
package sqt_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned HOT_W   = 21;
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 21;

  // Sine and cosine are Q1.15 in [-32768, 32768].
  localparam int unsigned TRIG_W = 17;

  localparam logic signed [COORD_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] OUT_MIN = 24'sh800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRITE_WIDTH  = 8'd0,
    REG_SPRITE_HEIGHT = 8'd1,
    REG_HOT_SPOT_X    = 8'd2,
    REG_HOT_SPOT_Y    = 8'd3
  } cfg_reg_t;

endpackage
`default_nettype wire

// ===== rtl/sprite_quad_transform.sv =====
// Sprite quad transform: six-stage pipeline from placement to quad corners
// and bounding box. Depends on sqt_pkg.
// One item is accepted every cycle while the output side takes results.
// The sine ROM read in stage one, the offset multipliers in stage two and
// the rotation multipliers in stage three set the stage depth.
// rst clears the valid bits and the configuration registers.
`default_nettype none
module sprite_quad_transform #(
  parameter int unsigned SINE_TABLE_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x[23:0], pos_y[47:24], angle[63:48], scale_h[79:64], scale_v[95:80]
  input  wire logic [95:0]                   s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
  // corner3_x, corner3_y, box_min_x, box_min_y, box_max_x, box_max_y,
  // 24 bits each from the lowest bit up
  output logic [287:0]                       m_axis_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sqt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sqt_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned TAB_N = 1 << SINE_TABLE_BITS;
  localparam int unsigned CW = sqt_pkg::COORD_W;
  localparam int unsigned TW = sqt_pkg::TRIG_W;
  localparam int unsigned OFS_BASE_W = 23;
  localparam int unsigned OFS_W = OFS_BASE_W + sqt_pkg::SCALE_W;
  localparam int unsigned PROD_W = OFS_W + TW;
  localparam int unsigned SUM_W = PROD_W + 2;
  localparam int unsigned RND_W = SUM_W - 23;

  typedef logic signed [TW-1:0] rom_t [TAB_N];

  function automatic logic signed [TW-1:0] sin_entry(input int unsigned i);
    longint unsigned u, u2, s;
    int unsigned q, k;
    q = (i >> (SINE_TABLE_BITS - 2)) & 3;
    k = i & ((TAB_N >> 2) - 1);
    u = longint'(k) << (32 - SINE_TABLE_BITS);
    if ((q & 1) != 0) u = (64'd1 << 30) - u;
    u2 = (u * u) >> 30;
    s = 3864;
    s = 172273 - ((s * u2) >> 30);
    s = 5026996 - ((s * u2) >> 30);
    s = 85569306 - ((s * u2) >> 30);
    s = 693598669 - ((s * u2) >> 30);
    s = 1686629713 - ((s * u2) >> 30);
    s = (s * u) >> 30;
    s = (s + 16384) >> 15;
    if (s > 32768) s = 32768;
    if ((q & 2) != 0) return -TW'(s);
    return TW'(s);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < TAB_N; i++) r[i] = sin_entry(i);
    return r;
  endfunction

  localparam rom_t SIN_ROM = build_rom();

  // Configuration registers; always ready.
  logic [sqt_pkg::SIZE_W-1:0]        sprite_width, sprite_height;
  logic signed [sqt_pkg::HOT_W-1:0]  hot_spot_x, hot_spot_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_width  <= '0;
      sprite_height <= '0;
      hot_spot_x    <= '0;
      hot_spot_y    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sqt_pkg::REG_SPRITE_WIDTH:  sprite_width  <= cfg_data[sqt_pkg::SIZE_W-1:0];
        sqt_pkg::REG_SPRITE_HEIGHT: sprite_height <= cfg_data[sqt_pkg::SIZE_W-1:0];
        sqt_pkg::REG_HOT_SPOT_X:    hot_spot_x    <= $signed(cfg_data);
        sqt_pkg::REG_HOT_SPOT_Y:    hot_spot_y    <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when it is empty or the next one moves.
  logic v1, v2, v3, v4, v5, v6;
  logic en1, en2, en3, en4, en5, en6;
  assign en6 = !v6 || m_axis_tready;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
    end else begin
      if (en1) v1 <= s_axis_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
    end
  end

  // Stage 1: unpack, pick scales, form the edge distances, read the ROM.
  logic signed [CW-1:0]  in_pos_x, in_pos_y;
  logic [sqt_pkg::ANGLE_W-1:0] in_angle;
  logic signed [sqt_pkg::SCALE_W-1:0] in_sh, in_sv;
  logic [SINE_TABLE_BITS-1:0] sin_idx, cos_idx;

  assign in_pos_x = $signed(s_axis_tdata[23:0]);
  assign in_pos_y = $signed(s_axis_tdata[47:24]);
  assign in_angle = s_axis_tdata[63:48];
  assign in_sh    = $signed(s_axis_tdata[79:64]);
  assign in_sv    = $signed(s_axis_tdata[95:80]);
  assign sin_idx  = in_angle[sqt_pkg::ANGLE_W-1 -: SINE_TABLE_BITS];
  assign cos_idx  = sin_idx + SINE_TABLE_BITS'(TAB_N >> 2);

  logic signed [CW-1:0] p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y;
  logic signed [sqt_pkg::SCALE_W-1:0] s1_sh, s1_sv;
  logic signed [OFS_BASE_W-1:0] s1_left, s1_right, s1_top, s1_bottom;
  logic signed [TW-1:0] s1_sin, s1_cos, s2_sin, s2_cos;

  always_ff @(posedge clk) begin
    if (en1) begin
      p1_x <= in_pos_x;
      p1_y <= in_pos_y;
      s1_sh <= in_sh;
      s1_sv <= (in_sv == '0) ? in_sh : in_sv;
      s1_left   <= -OFS_BASE_W'(hot_spot_x);
      s1_right  <= $signed({3'b000, sprite_width, 8'h00}) - OFS_BASE_W'(hot_spot_x);
      s1_top    <= -OFS_BASE_W'(hot_spot_y);
      s1_bottom <= $signed({3'b000, sprite_height, 8'h00}) - OFS_BASE_W'(hot_spot_y);
      // Zero angle bypasses the table: cosine one, sine zero.
      if (in_angle == '0) begin
        s1_sin <= '0;
        s1_cos <= TW'(32768);
      end else begin
        s1_sin <= SIN_ROM[sin_idx];
        s1_cos <= SIN_ROM[cos_idx];
      end
    end
  end

  // Stage 2: scaled offsets, exact Q.16.
  logic signed [OFS_W-1:0] dl, dr, dt, db;
  always_ff @(posedge clk) begin
    if (en2) begin
      p2_x <= p1_x;
      p2_y <= p1_y;
      s2_sin <= s1_sin;
      s2_cos <= s1_cos;
      dl <= s1_left * s1_sh;
      dr <= s1_right * s1_sh;
      dt <= s1_top * s1_sv;
      db <= s1_bottom * s1_sv;
    end
  end

  // Stage 3: rotation products.
  logic signed [PROD_W-1:0] lc, rc, ls, rs, tc, bc, ts, bs;
  always_ff @(posedge clk) begin
    if (en3) begin
      p3_x <= p2_x;
      p3_y <= p2_y;
      lc <= dl * s2_cos;
      rc <= dr * s2_cos;
      ls <= dl * s2_sin;
      rs <= dr * s2_sin;
      tc <= dt * s2_cos;
      bc <= db * s2_cos;
      ts <= dt * s2_sin;
      bs <= db * s2_sin;
    end
  end

  // Stage 4: sums in Q.31 with the rounding half added.
  logic signed [SUM_W-1:0] sum_x [4];
  logic signed [SUM_W-1:0] sum_y [4];
  logic signed [SUM_W-1:0] ofs_x, ofs_y;
  assign ofs_x = (SUM_W'(p3_x) <<< 23) + SUM_W'(64'sd4194304);
  assign ofs_y = (SUM_W'(p3_y) <<< 23) + SUM_W'(64'sd4194304);

  always_ff @(posedge clk) begin
    if (en4) begin
      // Corner order: top-left, top-right, bottom-right, bottom-left.
      sum_x[0] <= SUM_W'(lc) - SUM_W'(ts) + ofs_x;
      sum_x[1] <= SUM_W'(rc) - SUM_W'(ts) + ofs_x;
      sum_x[2] <= SUM_W'(rc) - SUM_W'(bs) + ofs_x;
      sum_x[3] <= SUM_W'(lc) - SUM_W'(bs) + ofs_x;
      sum_y[0] <= SUM_W'(ls) + SUM_W'(tc) + ofs_y;
      sum_y[1] <= SUM_W'(rs) + SUM_W'(tc) + ofs_y;
      sum_y[2] <= SUM_W'(rs) + SUM_W'(bc) + ofs_y;
      sum_y[3] <= SUM_W'(ls) + SUM_W'(bc) + ofs_y;
    end
  end

  function automatic logic signed [CW-1:0] round_sat(input logic signed [SUM_W-1:0] v);
    logic signed [RND_W-1:0] r;
    r = RND_W'(v >>> 23);
    if (r > RND_W'(sqt_pkg::OUT_MAX)) return sqt_pkg::OUT_MAX;
    if (r < RND_W'(sqt_pkg::OUT_MIN)) return sqt_pkg::OUT_MIN;
    return CW'(r);
  endfunction

  // Stage 5: round to Q.8 and saturate.
  logic signed [CW-1:0] cx [4];
  logic signed [CW-1:0] cy [4];
  always_ff @(posedge clk) begin
    if (en5) begin
      for (int k = 0; k < 4; k++) begin
        cx[k] <= round_sat(sum_x[k]);
        cy[k] <= round_sat(sum_y[k]);
      end
    end
  end

  // Stage 6: bounding box and output register.
  function automatic logic signed [CW-1:0] min2(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    return (b < a) ? b : a;
  endfunction
  function automatic logic signed [CW-1:0] max2(input logic signed [CW-1:0] a,
                                               input logic signed [CW-1:0] b);
    return (b > a) ? b : a;
  endfunction

  logic signed [CW-1:0] ox [4];
  logic signed [CW-1:0] oy [4];
  logic signed [CW-1:0] mnx, mny, mxx, mxy;
  always_ff @(posedge clk) begin
    if (en6) begin
      for (int k = 0; k < 4; k++) begin
        ox[k] <= cx[k];
        oy[k] <= cy[k];
      end
      mnx <= min2(min2(cx[0], cx[1]), min2(cx[2], cx[3]));
      mxx <= max2(max2(cx[0], cx[1]), max2(cx[2], cx[3]));
      mny <= min2(min2(cy[0], cy[1]), min2(cy[2], cy[3]));
      mxy <= max2(max2(cy[0], cy[1]), max2(cy[2], cy[3]));
    end
  end

  assign m_axis_tvalid = v6;
  assign m_axis_tdata = {mxy, mxx, mny, mnx, oy[3], ox[3], oy[2], ox[2],
                         oy[1], ox[1], oy[0], ox[0]};

  // The box min is checked against corners 0 and 2, the max against corners 1 and 3.
  a_box_x: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (mnx <= ox[0]) && (mnx <= ox[2]) && (mxx >= ox[1]) && (mxx >= ox[3]))
    else $error("box x does not enclose the corners");
  a_box_y: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (mny <= oy[0]) && (mny <= oy[2]) && (mxy >= oy[1]) && (mxy >= oy[3]))
    else $error("box y does not enclose the corners");
  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (en1 && s_axis_tvalid && in_angle == '0) |=> (s1_sin == '0 && s1_cos == TW'(32768)))
    else $error("zero angle did not bypass the table");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking bench for sprite_quad_transform: random and directed sprite
// placements against a bit-exact corner and bounding box predictor.
// Depends on sqt_pkg and the block's RTL.
module testbench;

  localparam int TAB_BITS = 12;
  localparam int TAB_N = 1 << TAB_BITS;
  localparam int CYCLE_LIMIT = 400000;

  class quad_scoreboard;
    int sine_tab[TAB_N];
    longint width_px, height_px, hot_x, hot_y;
    logic [287:0] expected_q[$];
    int mismatches, results_seen, items_seen;
    string field_names[12] = '{"corner0_x", "corner0_y", "corner1_x", "corner1_y",
                               "corner2_x", "corner2_y", "corner3_x", "corner3_y",
                               "box_min_x", "box_min_y", "box_max_x", "box_max_y"};

    function new();
      longint unsigned u;
      int q, k, v;
      for (int i = 0; i < TAB_N; i++) begin
        q = (i >> (TAB_BITS - 2)) & 3;
        k = i & (TAB_N / 4 - 1);
        u = longint'(k) << (32 - TAB_BITS);
        if (q & 1) u = (64'd1 << 30) - u;
        v = quarter_sine(u);
        sine_tab[i] = (q & 2) ? -v : v;
      end
    endfunction

    // Odd polynomial over one quarter turn, Q30 Horner steps.
    function int quarter_sine(longint unsigned u);
      longint unsigned u2, s;
      u2 = (u * u) >> 30;
      s = 3864;
      s = 172273 - ((s * u2) >> 30);
      s = 5026996 - ((s * u2) >> 30);
      s = 85569306 - ((s * u2) >> 30);
      s = 693598669 - ((s * u2) >> 30);
      s = 1686629713 - ((s * u2) >> 30);
      s = (s * u) >> 30;
      s = (s + 16384) >> 15;
      if (s > 32768) s = 32768;
      return int'(s);
    endfunction

    function void write_reg(logic [sqt_pkg::CFG_IDX_W-1:0] idx,
                            logic [sqt_pkg::CFG_DATA_W-1:0] d);
      case (idx)
        sqt_pkg::REG_SPRITE_WIDTH:  width_px = d[sqt_pkg::SIZE_W-1:0];
        sqt_pkg::REG_SPRITE_HEIGHT: height_px = d[sqt_pkg::SIZE_W-1:0];
        sqt_pkg::REG_HOT_SPOT_X:    hot_x = longint'($signed(d[sqt_pkg::HOT_W-1:0]));
        sqt_pkg::REG_HOT_SPOT_Y:    hot_y = longint'($signed(d[sqt_pkg::HOT_W-1:0]));
        default: ;
      endcase
    endfunction

    function logic signed [23:0] place(longint a, longint b, longint ka, longint kb,
                                       longint p);
      longint v;
      v = a * ka + b * kb + p * (64'sd1 <<< 23);
      v = (v + (64'sd1 <<< 22)) >>> 23;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
    endfunction

    function void note_input(logic [95:0] d);
      longint px, py, sh, sv, dl, dr, dt, db, c, s;
      logic [15:0] ang;
      longint dx[4], dy[4];
      logic signed [23:0] cx[4], cy[4], mnx, mxx, mny, mxy;
      int idx;
      px = longint'($signed(d[23:0]));
      py = longint'($signed(d[47:24]));
      ang = d[63:48];
      sh = longint'($signed(d[79:64]));
      sv = longint'($signed(d[95:80]));
      if (sv == 0) sv = sh;
      dl = -hot_x * sh;
      dr = (width_px * 256 - hot_x) * sh;
      dt = -hot_y * sv;
      db = (height_px * 256 - hot_y) * sv;
      c = 32768;
      s = 0;
      if (ang != 0) begin
        idx = ang >> (16 - TAB_BITS);
        s = sine_tab[idx];
        c = sine_tab[(idx + TAB_N / 4) % TAB_N];
      end
      dx = '{dl, dr, dr, dl};
      dy = '{dt, dt, db, db};
      for (int k = 0; k < 4; k++) begin
        cx[k] = place(dx[k], dy[k], c, -s, px);
        cy[k] = place(dx[k], dy[k], s, c, py);
      end
      mnx = cx[0]; mxx = cx[0]; mny = cy[0]; mxy = cy[0];
      for (int k = 1; k < 4; k++) begin
        if (cx[k] < mnx) mnx = cx[k];
        if (cx[k] > mxx) mxx = cx[k];
        if (cy[k] < mny) mny = cy[k];
        if (cy[k] > mxy) mxy = cy[k];
      end
      expected_q.push_back({mxy, mxx, mny, mnx, cy[3], cx[3], cy[2], cx[2],
                            cy[1], cx[1], cy[0], cx[0]});
      items_seen++;
    endfunction

    function void check_result(logic [287:0] d);
      logic [287:0] e;
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result arrived with no placement outstanding");
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      for (int f = 0; f < 12; f++)
        if (d[f*24 +: 24] !== e[f*24 +: 24]) begin
          $error("%s: expected %0d, actual %0d", field_names[f],
                 $signed(e[f*24 +: 24]), $signed(d[f*24 +: 24]));
          mismatches++;
        end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [287:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sqt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sqt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  quad_scoreboard board = new();
  int cycles = 0;
  bit steady = 1'b0;      // no idling on either side while set
  bit hold_off = 1'b0;
  int config_writes = 0;

  sprite_quad_transform i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) board.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk)
    m_axis_tready <= !rst && !hold_off && (steady || $urandom_range(99) >= 18);

  task automatic write_reg(input sqt_pkg::cfg_reg_t idx,
                           input logic [sqt_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    config_writes++;
  endtask

  task automatic send_item(input logic signed [23:0] px, input logic signed [23:0] py,
                           input logic [15:0] ang, input logic signed [15:0] sh,
                           input logic signed [15:0] sv);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sv, sh, ang, py, px};
    do @(posedge clk); while (!s_axis_tready);
    if (!steady && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [23:0] pick24();
    case ($urandom_range(9))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2, 3, 4: return 24'($urandom_range(8191) - 4096);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3, 4, 5: return 16'($urandom_range(1024) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'($urandom_range(15));
      2: return {2'($urandom_range(3)), 14'h0};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_items(input int n);
    logic [15:0] sh;
    for (int i = 0; i < n; i++) begin
      sh = pick_scale();
      send_item(pick24(), pick24(), pick_angle(), sh,
                $urandom_range(3) == 0 ? 16'h0 : pick_scale());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration, then a plain sprite with its hot spot at x 16, y -8 pixels.
    send_item(24'sd0, 24'sd0, 16'd0, 16'sh0100, 16'sh0000);
    drain();
    write_reg(sqt_pkg::REG_SPRITE_WIDTH, 21'd32);
    write_reg(sqt_pkg::REG_SPRITE_HEIGHT, 21'd16);
    write_reg(sqt_pkg::REG_HOT_SPOT_X, 21'd4096);
    write_reg(sqt_pkg::REG_HOT_SPOT_Y, 21'h1FF800);
    // An unknown index must leave every register alone.
    write_reg(sqt_pkg::cfg_reg_t'(8'd77), 21'h1FFFFF);
    write_reg(sqt_pkg::cfg_reg_t'(8'd255), 21'h0ABCDE);

    send_item(24'sd2560, -24'sd1280, 16'd0, 16'sh0100, 16'sh0000);
    send_item(24'sd2560, -24'sd1280, 16'd1, 16'sh0100, 16'sh0200);
    send_item(24'sd2560, -24'sd1280, 16'd15, 16'sh0080, 16'sh0000);
    send_item(24'sd0, 24'sd0, 16'd16384, 16'sh0100, 16'sh0100);
    send_item(24'sd0, 24'sd0, 16'd32768, 16'sh0100, -16'sh0100);
    send_item(24'sd0, 24'sd0, 16'd49152, -16'sh0100, 16'sh0000);
    send_item(24'sd0, 24'sd0, 16'd65535, 16'sh0100, 16'sh0300);
    send_item(24'sd0, 24'sd0, 16'd8192, 16'sh7FFF, 16'sh8000);
    send_item(24'sh7FFFFF, 24'sh7FFFFF, 16'd0, 16'sh7FFF, 16'sh0000);
    send_item(24'sh800000, 24'sh800000, 16'd0, 16'sh7FFF, 16'sh0000);
    send_item(24'sh800000, 24'sh7FFFFF, 16'd24576, 16'sh8000, 16'sh7FFF);
    send_item(24'sh7FFFFF, 24'sh800000, 16'd40000, 16'sh0001, 16'sh8000);
    drain();

    // Extreme registers, saturation is common here.
    write_reg(sqt_pkg::REG_SPRITE_WIDTH, 21'h1FFFFF);
    write_reg(sqt_pkg::REG_SPRITE_HEIGHT, 21'd4095);
    write_reg(sqt_pkg::REG_HOT_SPOT_X, 21'h100000);
    write_reg(sqt_pkg::REG_HOT_SPOT_Y, 21'h0FFFFF);
    send_item(24'sd0, 24'sd0, 16'd0, 16'sh8000, 16'sh0000);
    send_item(24'sd0, 24'sd0, 16'd12345, 16'sh7FFF, 16'sh8000);
    send_item(24'sd100, 24'sd100, 16'd0, 16'sh0001, 16'sh0001);
    random_items(100);
    drain();

    // Several random settings, including an all-zero one.
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(sqt_pkg::REG_SPRITE_WIDTH,
                phase == 0 ? 21'd0 : 21'($urandom_range(300)));
      write_reg(sqt_pkg::REG_SPRITE_HEIGHT,
                phase == 0 ? 21'd0 : 21'($urandom_range(4095)));
      write_reg(sqt_pkg::REG_HOT_SPOT_X, phase == 0 ? 21'd0 : 21'($urandom));
      write_reg(sqt_pkg::REG_HOT_SPOT_Y,
                phase == 0 ? 21'd0 : 21'($urandom_range(40000)));
      steady = (phase == 3);
      // Receiver stalls for a long stretch while items keep coming.
      if (phase == 5) fork
        begin
          hold_off = 1'b1;
          repeat (300) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      random_items(160);
      drain();
    end
    steady = 1'b0;

    $display("Covered %0d placements and %0d results over %0d register writes,",
             board.items_seen, board.results_seen, config_writes);
    $display("with zero, extreme and random sprite sizes, hot spots and angles.");
    if (board.mismatches == 0 && board.expected_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
